// File: hw/rtl/mfbp_pkg.sv
`default_nettype none

package mfbp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FILL_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic accept;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic emits;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/msb_first_bit_packer_unit.sv
// Output: the first byte of an item is offered in the cycle after its transfer.
// Flow: an item that completes N bytes (N up to (7 + MAX_FIELD_BITS) / 8) is
// drained from the top of the accumulator one byte per cycle while out_stall_i is low;
// no new item is taken until its last byte is transferred.
// Reset: asynchronous, active low; clears the partial byte and its bit count.
`default_nettype none

module msb_first_bit_packer_unit #(
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         op_i,
  input  wire logic [mfbp_pkg::VALUE_W-1:0] value_i,
  input  wire logic [mfbp_pkg::COUNT_W-1:0] bit_count_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [mfbp_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                              last_of_item_o
);
  import mfbp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mfbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mfbp_datapath #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op_i),
    .value_i        (value_i),
    .bit_count_i    (bit_count_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o)
  );

  a_busy_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while bytes are pending");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_of_item_o) |=> !out_valid_o)
    else $error("byte offered after the last byte of an item");

  a_more_after_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_of_item_o) |=> out_valid_o)
    else $error("item ended without a last byte");

  a_accept_only_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && !sts.emits) |=> !out_valid_o)
    else $error("byte offered for an item that completes none");

endmodule

`default_nettype wire

// File: hw/rtl/mfbp_ctrl.sv
`default_nettype none

module mfbp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire mfbp_pkg::sts_t sts_i,
  output mfbp_pkg::cmd_t     cmd_o
);
  import mfbp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.emits) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          cmd_o.shift = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mfbp_datapath.sv
`default_nettype none

module mfbp_datapath #(
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            op_i,
  input  wire logic [mfbp_pkg::VALUE_W-1:0]    value_i,
  input  wire logic [mfbp_pkg::COUNT_W-1:0]    bit_count_i,
  input  wire mfbp_pkg::cmd_t                  cmd_i,
  output mfbp_pkg::sts_t                       sts_o,
  output logic [mfbp_pkg::BYTE_W-1:0]          out_byte_o,
  output logic                                 last_of_item_o
);
  import mfbp_pkg::*;

  localparam int unsigned ACC_W     = MAX_FIELD_BITS + BYTE_W;
  localparam int unsigned MAX_BYTES = (BYTE_W - 1 + MAX_FIELD_BITS) / BYTE_W;
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int unsigned TOT_W     = $clog2(ACC_W + 1);
  localparam int unsigned CMP_W     = (COUNT_W > TOT_W) ? COUNT_W + 1 : TOT_W + 1;

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              count_ok;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  shamt;
  logic [ACC_W-1:0]  field;

  assign count_ok = (bit_count_i != '0) &&
                    (CMP_W'(bit_count_i) <= CMP_W'(MAX_FIELD_BITS));
  assign total    = TOT_W'(fill_q) + TOT_W'(bit_count_i);
  assign shamt    = TOT_W'(ACC_W) - total;
  assign field    = ACC_W'(value_i) & ((ACC_W'(1) << bit_count_i) - ACC_W'(1));

  always_comb begin
    if (op_i == OP_FLUSH) begin
      sts_o.emits = (fill_q != '0);
    end else begin
      sts_o.emits = count_ok && (total >= TOT_W'(BYTE_W));
    end
    sts_o.last = (cnt_q == CNT_W'(1));
  end

  always_comb begin
    acc_d  = acc_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    if (cmd_i.accept) begin
      if (op_i == OP_FLUSH) begin
        if (fill_q != '0) begin
          cnt_d  = CNT_W'(1);
          fill_d = '0;
        end
      end else if (count_ok) begin
        acc_d  = acc_q | (field << shamt);
        cnt_d  = CNT_W'(total >> FILL_W);
        fill_d = total[FILL_W-1:0];
      end
    end else if (cmd_i.shift) begin
      acc_d = acc_q << BYTE_W;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign out_byte_o     = acc_q[ACC_W-1 -: BYTE_W];
  assign last_of_item_o = sts_o.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      fill_q <= '0;
      cnt_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/msb_first_bit_packer_unit_tb.sv
`default_nettype none

module msb_first_bit_packer_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mfbp_pkg::*;

  localparam int unsigned FIELD_MAX  = 32;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned DRAIN_WAIT = 8;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               op_i = OP_APPEND;
  logic [VALUE_W-1:0] value_i = '0;
  logic [COUNT_W-1:0] bit_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [BYTE_W-1:0]  out_byte_o;
  logic               last_of_item_o;

  packed_byte_t       byte_q[$];
  logic [BYTE_W-1:0]  acc_byte = '0;
  int unsigned        acc_fill = 0;

  int unsigned        sender_idle_pct = 0;
  int unsigned        receiver_stall_pct = 0;
  logic               hold_off = 1'b0;

  int unsigned        error_cnt = 0;
  int unsigned        items_in = 0;
  int unsigned        bytes_out = 0;
  int unsigned        flushes_in = 0;
  int unsigned        cycle_cnt = 0;

  msb_first_bit_packer_unit #(
    .MAX_FIELD_BITS(FIELD_MAX)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .bit_count_i   (bit_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_item_o(last_of_item_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void pack_field(input logic op, input logic [VALUE_W-1:0] value,
                                     input logic [COUNT_W-1:0] count);
    int unsigned first_new;
    packed_byte_t done_byte;
    first_new = byte_q.size();
    if (op == OP_FLUSH) begin
      if (acc_fill != 0) begin
        done_byte.data = acc_byte;
        done_byte.last = 1'b0;
        byte_q.push_back(done_byte);
        acc_byte = '0;
        acc_fill = 0;
      end
    end else if (count != 0 && count <= FIELD_MAX) begin
      for (int i = int'(count) - 1; i >= 0; i--) begin
        if (value[i]) begin
          acc_byte[7 - acc_fill] = 1'b1;
        end
        acc_fill++;
        if (acc_fill == BYTE_W) begin
          done_byte.data = acc_byte;
          done_byte.last = 1'b0;
          byte_q.push_back(done_byte);
          acc_byte = '0;
          acc_fill = 0;
        end
      end
    end
    if (byte_q.size() > first_new) begin
      byte_q[byte_q.size() - 1].last = 1'b1;
    end
  endfunction

  // Prediction runs before checking so an item and its bytes stay in order.
  always @(posedge clk_i) begin
    packed_byte_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pack_field(op_i, value_i, bit_count_i);
        items_in++;
        if (op_i == OP_FLUSH) begin
          flushes_in++;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        bytes_out++;
        if (byte_q.size() == 0) begin
          $error("unexpected transfer: out_byte %h, last_of_item %b", out_byte_o,
                 last_of_item_o);
          error_cnt++;
        end else begin
          want = byte_q.pop_front();
          if (out_byte_o !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_byte_o);
            error_cnt++;
          end
          if (last_of_item_o !== want.last) begin
            $error("last_of_item: expected %b, actual %b", want.last, last_of_item_o);
            error_cnt++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("[msb_first_bit_packer_unit] ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [VALUE_W-1:0] value,
                           input logic [COUNT_W-1:0] count);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    op_i        = op;
    value_i     = value;
    bit_count_i = count;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [COUNT_W-1:0] count;
    pick = $urandom_range(99);
    if (pick < 10) begin
      count = COUNT_W'($urandom_range(63));
      send_item(OP_FLUSH, $urandom(), count);
    end else if (pick < 13) begin
      send_item(OP_APPEND, $urandom(), '0);
    end else if (pick < 16) begin
      count = COUNT_W'($urandom_range(63, FIELD_MAX + 1));
      send_item(OP_APPEND, $urandom(), count);
    end else if (pick < 36) begin
      send_item(OP_APPEND, $urandom(), COUNT_W'(FIELD_MAX));
    end else if (pick < 56) begin
      count = COUNT_W'($urandom_range(FIELD_MAX - 1, 17));
      send_item(OP_APPEND, $urandom(), count);
    end else begin
      count = COUNT_W'($urandom_range(16, 1));
      send_item(OP_APPEND, $urandom(), count);
    end
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (byte_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_edge_fields();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd33);
    send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd63);
    send_item(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);
    send_item(OP_APPEND, 32'h0000_0001, 6'd1);
    send_item(OP_APPEND, 32'h0000_007F, 6'd7);
    send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd32);
    send_item(OP_APPEND, 32'h0000_0000, 6'd32);
    send_item(OP_APPEND, 32'hFFFF_FFFD, 6'd3);
    send_item(OP_APPEND, 32'hA5A5_A5A5, 6'd32);
    send_item(OP_FLUSH, 32'h0000_0000, 6'd0);
    send_item(OP_FLUSH, 32'h1234_5678, 6'd12);
    send_item(OP_APPEND, 32'hFFFF_FF80, 6'd8);
    send_item(OP_APPEND, 32'hFFFF_FFE5, 6'd5);
    send_item(OP_APPEND, 32'h0000_0003, 6'd2);
    send_item(OP_FLUSH, 32'hFFFF_FFFF, 6'd32);
    send_item(OP_APPEND, 32'h8000_0001, 6'd32);
    send_item(OP_APPEND, 32'h0000_0001, 6'd1);
    send_item(OP_APPEND, 32'h7FFF_FFFF, 6'd31);
    send_item(OP_FLUSH, 32'h0000_0000, 6'd0);
    wait_drained();
  endtask

  task automatic test_random_stream(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned n_items);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n_items) send_random_item();
    wait_drained();
  endtask

  task automatic test_output_hold();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    fork
      begin
        @(posedge clk_i);
        hold_off = 1'b1;
        repeat (150) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (20) send_item(OP_APPEND, $urandom(), COUNT_W'(FIELD_MAX));
      end
    join
    send_item(OP_APPEND, $urandom(), 6'd5);
    send_item(OP_FLUSH, '0, '0);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_edge_fields();
    test_random_stream(0, 0, 15);
    test_random_stream(54, 0, 15);
    test_random_stream(0, 54, 15);
    test_random_stream(16, 16, 15);
    test_output_hold();
    $display("Sent %0d items (%0d flushes) and checked %0d packed bytes,", items_in,
             flushes_in, bytes_out);
    $display("with edge counts, idle and stall mixes, and a long output hold-off.");
    if (error_cnt == 0) begin
      $display("[msb_first_bit_packer_unit] OK");
    end else begin
      $display("[msb_first_bit_packer_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
